// ----- rtl/frt_pkg.sv -----
package frt_pkg;

   // Table geometry.
   localparam int SLOTS         = 8;
   localparam int MAX_FRAGMENTS = 64;

   localparam int SLOT_IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FRAG_CNT_W = $clog2(MAX_FRAGMENTS + 1);
   localparam int MAP_W      = MAX_FRAGMENTS;
   localparam int MAP_IW     = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;

   // Port field widths.
   localparam int CMD_W      = 2;
   localparam int ID_W       = 32;
   localparam int FIDX_W     = 16;
   localparam int SIZE_W     = 32;
   localparam int LEN_W      = 16;
   localparam int TIME_W     = 64;
   localparam int STATUS_W   = 4;
   localparam int SLOT_OUT_W = 3;
   localparam int MASK_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_FRAG     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SWEEP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_INVALID  = 4'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 4'd1;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 4'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 4'd3;
   localparam logic [STATUS_W-1:0] ST_STORED   = 4'd4;
   localparam logic [STATUS_W-1:0] ST_DUP      = 4'd5;
   localparam logic [STATUS_W-1:0] ST_COMPLETE = 4'd6;
   localparam logic [STATUS_W-1:0] ST_SIZE_ERR = 4'd7;
   localparam logic [STATUS_W-1:0] ST_SWEPT    = 4'd8;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 4'd9;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAG_CAP  = 2'd2;

   localparam logic [31:0] TIMEOUT_RST   = 32'd5000;
   localparam logic [31:0] MAX_BYTES_RST = 32'd65536;
   localparam logic [15:0] FRAG_CAP_RST  = 16'd1024;

   typedef struct packed {
      logic [31:0] idle_timeout;
      logic [31:0] max_transfer_bytes;
      logic [15:0] fragment_capacity;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ID_W-1:0]   xfer_id;
      logic [FIDX_W-1:0] frag_index;
      logic [FIDX_W-1:0] frag_count;
      logic [SIZE_W-1:0] xfer_bytes;
      logic [LEN_W-1:0]  payload_len;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  write_payload;
      logic [SIZE_W-1:0]     completed_size;
      logic [MASK_W-1:0]     expired_mask;
   } rsp_type;

endpackage

// ----- rtl/fragment_reassembly_tracker_unit.sv -----
// Fragment reassembly tracker. Every fragment header, expire sweep or clear
// command is taken on a clock edge where start is high and busy is low; busy
// is raised only while reset is held, so after reset one command can be
// issued on every clock. Each command produces exactly one result, shown for
// a single cycle with rsp_valid high. The edge that takes the command's
// transfer loads the input register, and the next edge loads the result
// register after the header check, the parallel compare of all slot ids and
// the slot update. Commands take effect in order, so a command sees the
// table as left by the one before it. The receiver cannot stall the result;
// it must take every result in the cycle it is shown. Registers are written
// over the csr_ port, which is ready whenever reset is low, and must only be
// written while no command is in flight.
module fragment_reassembly_tracker_unit (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              start,
   output logic                              busy,
   input  logic [frt_pkg::CMD_W-1:0]         req_cmd,
   input  logic [frt_pkg::ID_W-1:0]          req_transfer_id,
   input  logic [frt_pkg::FIDX_W-1:0]        req_frag_index,
   input  logic [frt_pkg::FIDX_W-1:0]        req_frag_count,
   input  logic [frt_pkg::SIZE_W-1:0]        req_total_size,
   input  logic [frt_pkg::LEN_W-1:0]         req_payload_len,
   input  logic [frt_pkg::TIME_W-1:0]        req_now_ms,

   output logic                              rsp_valid,
   output logic [frt_pkg::STATUS_W-1:0]      rsp_status,
   output logic [frt_pkg::SLOT_OUT_W-1:0]    rsp_slot,
   output logic                              rsp_write_payload,
   output logic [frt_pkg::SIZE_W-1:0]        rsp_completed_size,
   output logic [frt_pkg::MASK_W-1:0]        rsp_expired_mask,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [frt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [frt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import frt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   req_type req_ff;
   req_type req_in;
   logic    req_valid_ff;
   logic    accept;
   logic    hdr_ok;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   // The pipeline has no back pressure, so a command is taken every cycle
   // once reset is released.
   assign busy      = reset;
   assign csr_ready = !reset;
   assign accept    = start && !busy;

   // Register file. An index past the last register is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIMEOUT:   cfg_in.idle_timeout       = csr_wdata;
            CSR_MAX_BYTES: cfg_in.max_transfer_bytes = csr_wdata;
            CSR_FRAG_CAP:  cfg_in.fragment_capacity  = csr_wdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout       <= TIMEOUT_RST;
         cfg_ff.max_transfer_bytes <= MAX_BYTES_RST;
         cfg_ff.fragment_capacity  <= FRAG_CAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: captures the command on its transfer.
   always_comb begin
      req_in.cmd         = req_cmd;
      req_in.xfer_id     = req_transfer_id;
      req_in.frag_index  = req_frag_index;
      req_in.frag_count  = req_frag_count;
      req_in.xfer_bytes  = req_total_size;
      req_in.payload_len = req_payload_len;
      req_in.now_ms      = req_now_ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
      if (accept) begin
         req_ff <= req_in;
      end
   end

   frt_header_check u_check (
      .req    (req_ff),
      .cfg    (cfg_ff),
      .hdr_ok (hdr_ok)
   );

   // The slot table updates its state on the same edge that loads the result.
   frt_slot_table u_table (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_valid_ff),
      .req        (req_ff),
      .hdr_ok     (hdr_ok),
      .cfg        (cfg_ff),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_slot           = rsp_ff.slot;
   assign rsp_write_payload  = rsp_ff.write_payload;
   assign rsp_completed_size = rsp_ff.completed_size;
   assign rsp_expired_mask   = rsp_ff.expired_mask;

endmodule

// ----- rtl/frt_header_check.sv -----
module frt_header_check (
   input  frt_pkg::req_type req,
   input  frt_pkg::cfg_type cfg,
   output logic             hdr_ok
);
   import frt_pkg::*;

   always_comb begin
      hdr_ok = (req.xfer_id != '0)
            && (req.frag_count != '0)
            && (req.frag_index < req.frag_count)
            && (req.frag_count <= FIDX_W'(MAX_FRAGMENTS))
            && (req.xfer_bytes != '0)
            && (req.xfer_bytes <= cfg.max_transfer_bytes)
            && (req.payload_len != '0)
            && (req.payload_len <= cfg.fragment_capacity);
   end

endmodule

// ----- rtl/frt_slot_table.sv -----
module frt_slot_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  frt_pkg::req_type req,
   input  logic             hdr_ok,
   input  frt_pkg::cfg_type cfg,
   output frt_pkg::rsp_type rsp
);
   import frt_pkg::*;

   logic                  valid_ff      [SLOTS];
   logic                  valid_in      [SLOTS];
   logic [ID_W-1:0]       id_ff         [SLOTS];
   logic [ID_W-1:0]       id_in         [SLOTS];
   logic [FRAG_CNT_W-1:0] frag_total_ff [SLOTS];
   logic [FRAG_CNT_W-1:0] frag_total_in [SLOTS];
   logic [SIZE_W-1:0]     byte_total_ff [SLOTS];
   logic [SIZE_W-1:0]     byte_total_in [SLOTS];
   logic [SIZE_W-1:0]     bytes_seen_ff [SLOTS];
   logic [SIZE_W-1:0]     bytes_seen_in [SLOTS];
   logic [FRAG_CNT_W-1:0] frags_seen_ff [SLOTS];
   logic [FRAG_CNT_W-1:0] frags_seen_in [SLOTS];
   logic [TIME_W-1:0]     last_upd_ff   [SLOTS];
   logic [TIME_W-1:0]     last_upd_in   [SLOTS];
   logic [MAP_W-1:0]      seen_map_ff   [SLOTS];
   logic [MAP_W-1:0]      seen_map_in   [SLOTS];

   logic [SLOTS-1:0]      match_vec;
   logic [SLOTS-1:0]      free_vec;
   logic [SLOTS-1:0]      expire_vec;
   logic [SLOT_IW-1:0]    match_idx;
   logic [SLOT_IW-1:0]    free_idx;
   logic [SLOT_IW-1:0]    sel;
   logic                  is_new;

   logic [FRAG_CNT_W-1:0] cur_frag_total;
   logic [SIZE_W-1:0]     cur_byte_total;
   logic [SIZE_W-1:0]     cur_bytes;
   logic [FRAG_CNT_W-1:0] cur_frags;
   logic [MAP_W-1:0]      cur_map;
   logic [SIZE_W-1:0]     len_ext;
   logic [SIZE_W-1:0]     room;
   logic [SIZE_W-1:0]     new_bytes;
   logic [FRAG_CNT_W-1:0] new_frags;
   logic [MAP_W-1:0]      idx_bit;
   logic                  mismatch;
   logic                  dup;
   logic                  overflow;
   logic                  done;

   // Parallel compare against every slot, plus per-slot age check.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_vec[i]  = valid_ff[i] && (id_ff[i] == req.xfer_id);
         free_vec[i]   = !valid_ff[i];
         expire_vec[i] = valid_ff[i] && (req.now_ms >= last_upd_ff[i])
                      && ((req.now_ms - last_upd_ff[i]) > TIME_W'(cfg.idle_timeout));
      end
   end

   // Lowest-index priority encoders.
   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_idx = SLOT_IW'(i);
         end
         if (free_vec[i]) begin
            free_idx = SLOT_IW'(i);
         end
      end
   end

   assign is_new = (match_vec == '0);
   assign sel    = is_new ? free_idx : match_idx;

   // A freshly allocated slot starts from the header's totals and empty counters.
   always_comb begin
      cur_frag_total = is_new ? FRAG_CNT_W'(req.frag_count) : frag_total_ff[sel];
      cur_byte_total = is_new ? req.xfer_bytes : byte_total_ff[sel];
      cur_bytes      = is_new ? '0 : bytes_seen_ff[sel];
      cur_frags      = is_new ? '0 : frags_seen_ff[sel];
      cur_map        = is_new ? '0 : seen_map_ff[sel];
   end

   always_comb begin
      len_ext   = SIZE_W'(req.payload_len);
      mismatch  = (FIDX_W'(cur_frag_total) != req.frag_count)
               || (cur_byte_total != req.xfer_bytes);
      idx_bit   = MAP_W'(1) << req.frag_index[MAP_IW-1:0];
      dup       = (cur_map & idx_bit) != '0;
      room      = cur_byte_total - ((len_ext < cur_byte_total) ? len_ext : cur_byte_total);
      overflow  = cur_bytes > room;
      new_bytes = cur_bytes + len_ext;
      new_frags = cur_frags + FRAG_CNT_W'(1);
      done      = (new_frags == cur_frag_total);
   end

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         valid_in[i]      = valid_ff[i];
         id_in[i]         = id_ff[i];
         frag_total_in[i] = frag_total_ff[i];
         byte_total_in[i] = byte_total_ff[i];
         bytes_seen_in[i] = bytes_seen_ff[i];
         frags_seen_in[i] = frags_seen_ff[i];
         last_upd_in[i]   = last_upd_ff[i];
         seen_map_in[i]   = seen_map_ff[i];
      end
      rsp = '0;

      if (item_valid) begin
         unique case (req.cmd)
            CMD_FRAG: begin
               if (!hdr_ok) begin
                  rsp.status = ST_INVALID;
               end else if (is_new && (free_vec == '0)) begin
                  rsp.status = ST_FULL;
               end else begin
                  rsp.slot = SLOT_OUT_W'(sel);
                  if (is_new) begin
                     valid_in[sel]      = 1'b1;
                     id_in[sel]         = req.xfer_id;
                     frag_total_in[sel] = cur_frag_total;
                     byte_total_in[sel] = cur_byte_total;
                     bytes_seen_in[sel] = cur_bytes;
                     frags_seen_in[sel] = cur_frags;
                     seen_map_in[sel]   = cur_map;
                  end
                  if (mismatch) begin
                     valid_in[sel] = 1'b0;
                     rsp.status    = ST_MISMATCH;
                  end else begin
                     last_upd_in[sel] = req.now_ms;
                     if (dup) begin
                        rsp.status = ST_DUP;
                     end else if (overflow) begin
                        valid_in[sel] = 1'b0;
                        rsp.status    = ST_OVERFLOW;
                     end else begin
                        bytes_seen_in[sel] = new_bytes;
                        frags_seen_in[sel] = new_frags;
                        seen_map_in[sel]   = cur_map | idx_bit;
                        rsp.write_payload  = 1'b1;
                        if (!done) begin
                           rsp.status = ST_STORED;
                        end else begin
                           valid_in[sel] = 1'b0;
                           if (new_bytes != cur_byte_total) begin
                              rsp.status = ST_SIZE_ERR;
                           end else begin
                              rsp.status         = ST_COMPLETE;
                              rsp.completed_size = cur_byte_total;
                           end
                        end
                     end
                  end
               end
            end
            CMD_SWEEP: begin
               for (int i = 0; i < SLOTS; i++) begin
                  valid_in[i] = valid_ff[i] && !expire_vec[i];
               end
               rsp.status       = ST_SWEPT;
               rsp.expired_mask = MASK_W'(expire_vec);
            end
            CMD_CLEAR: begin
               for (int i = 0; i < SLOTS; i++) begin
                  valid_in[i] = 1'b0;
               end
               rsp.status = ST_CLEARED;
            end
            default: begin
               rsp.status = ST_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_in[i];
         end
         id_ff[i]         <= id_in[i];
         frag_total_ff[i] <= frag_total_in[i];
         byte_total_ff[i] <= byte_total_in[i];
         bytes_seen_ff[i] <= bytes_seen_in[i];
         frags_seen_ff[i] <= frags_seen_in[i];
         last_upd_ff[i]   <= last_upd_in[i];
         seen_map_ff[i]   <= seen_map_in[i];
      end
   end

endmodule

// ----- rtl/frt_checker.sv -----
module frt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [frt_pkg::STATUS_W-1:0]      rsp_status,
   input logic [frt_pkg::SLOT_OUT_W-1:0]    rsp_slot,
   input logic                              rsp_write_payload,
   input logic [frt_pkg::SIZE_W-1:0]        rsp_completed_size,
   input logic [frt_pkg::MASK_W-1:0]        rsp_expired_mask
);
   import frt_pkg::*;

   // Every accepted command yields a result.
   a_cmd_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted command produced no result");

   // No result appears without an accepted command before it.
   a_rsp_from_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a command");

   // A completed transfer always asks for its last payload and has a size.
   a_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_COMPLETE) |->
         (rsp_write_payload && rsp_completed_size != '0))
      else $error("completion without payload write or size");

   // Only a sweep reports freed slots.
   a_mask_sweep: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_SWEPT) |-> (rsp_expired_mask == '0))
      else $error("expired mask outside a sweep");

   // Results that use no slot name slot zero and never ask for a payload write.
   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_INVALID || rsp_status == ST_FULL
                  || rsp_status == ST_SWEPT || rsp_status == ST_CLEARED)) |->
         (rsp_slot == '0 && !rsp_write_payload))
      else $error("slot or payload write on a slotless result");

endmodule

bind fragment_reassembly_tracker_unit frt_checker u_frt_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_status         (rsp_status),
   .rsp_slot           (rsp_slot),
   .rsp_write_payload  (rsp_write_payload),
   .rsp_completed_size (rsp_completed_size),
   .rsp_expired_mask   (rsp_expired_mask)
);

// ----- dv/tb_top.sv -----
module tb_top;
   import frt_pkg::*;

   // Cycles without any transfer on the command, result or register channels
   // before the run is declared hung, far beyond any legal quiet stretch.
   localparam int QUIET_LIMIT = 2000;

   // Number of transfers the stimulus can keep open at once. It exceeds the
   // table size on purpose so that the table-full path is reached.
   localparam int PLANS = 10;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [CMD_W-1:0]        req_cmd;
   logic [ID_W-1:0]         req_transfer_id;
   logic [FIDX_W-1:0]       req_frag_index;
   logic [FIDX_W-1:0]       req_frag_count;
   logic [SIZE_W-1:0]       req_total_size;
   logic [LEN_W-1:0]        req_payload_len;
   logic [TIME_W-1:0]       req_now_ms;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic [SLOT_OUT_W-1:0]   rsp_slot;
   logic                    rsp_write_payload;
   logic [SIZE_W-1:0]       rsp_completed_size;
   logic [MASK_W-1:0]       rsp_expired_mask;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   fragment_reassembly_tracker_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_transfer_id    (req_transfer_id),
      .req_frag_index     (req_frag_index),
      .req_frag_count     (req_frag_count),
      .req_total_size     (req_total_size),
      .req_payload_len    (req_payload_len),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_write_payload  (rsp_write_payload),
      .rsp_completed_size (rsp_completed_size),
      .rsp_expired_mask   (rsp_expired_mask),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Register values as the testbench believes the block holds them.
   logic [31:0] cfg_timeout;
   logic [31:0] cfg_max_bytes;
   logic [15:0] cfg_frag_cap;

   // Shadow copy of the reassembly table.
   logic                  tbl_valid      [SLOTS];
   logic [ID_W-1:0]       tbl_id         [SLOTS];
   logic [FRAG_CNT_W-1:0] tbl_frag_total [SLOTS];
   logic [SIZE_W-1:0]     tbl_byte_total [SLOTS];
   logic [SIZE_W-1:0]     tbl_bytes_seen [SLOTS];
   logic [FRAG_CNT_W-1:0] tbl_frags_seen [SLOTS];
   logic [TIME_W-1:0]     tbl_last       [SLOTS];
   logic [MAP_W-1:0]      tbl_seen       [SLOTS];

   // Outcomes owed by the block, oldest first.
   rsp_type results_due[$];

   int mismatch_count;
   int quiet_cycles;
   int sender_gap_pct;

   // Stimulus bookkeeping: the link clock and the transfers being sent. A
   // plan is a transfer whose fragments go out in a shuffled order.
   logic [63:0] link_ms;
   int          active_plans;
   logic [31:0] plan_id    [PLANS];
   int          plan_cnt   [PLANS];
   int          plan_sent  [PLANS];
   logic [31:0] plan_total [PLANS];
   logic [15:0] plan_len   [PLANS][MAX_FRAGMENTS];
   logic [15:0] plan_order [PLANS][MAX_FRAGMENTS];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Works out what the block must answer for one command and moves the
   // shadow table forward the same way the block is meant to.
   function automatic rsp_type table_outcome(input req_type it);
      rsp_type     r;
      int          s;
      int          hit;
      logic [31:0] room;
      logic [31:0] take;
      logic [MAP_IW-1:0] pos;
      r = '0;
      hit = -1;
      if (it.cmd == CMD_SWEEP) begin
         // A slot whose last update lies in the future never ages out.
         for (s = 0; s < SLOTS; s++) begin
            if (tbl_valid[s] && it.now_ms >= tbl_last[s] &&
                it.now_ms - tbl_last[s] > {32'd0, cfg_timeout}) begin
               tbl_valid[s] = 1'b0;
               r.expired_mask[s] = 1'b1;
            end
         end
         r.status = ST_SWEPT;
         return r;
      end
      if (it.cmd == CMD_CLEAR) begin
         for (s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
         r.status = ST_CLEARED;
         return r;
      end
      // The unused command code answers like a rejected header.
      if (it.cmd != CMD_FRAG) return r;

      if (it.xfer_id == '0 || it.frag_count == '0 || it.frag_index >= it.frag_count ||
          it.frag_count > MAX_FRAGMENTS || it.xfer_bytes == '0 ||
          it.xfer_bytes > cfg_max_bytes || it.payload_len == '0 ||
          it.payload_len > cfg_frag_cap)
         return r;

      for (s = 0; s < SLOTS; s++)
         if (hit < 0 && tbl_valid[s] && tbl_id[s] == it.xfer_id) hit = s;
      if (hit < 0) begin
         for (s = 0; s < SLOTS; s++)
            if (hit < 0 && !tbl_valid[s]) hit = s;
         if (hit < 0) begin
            r.status = ST_FULL;
            return r;
         end
         tbl_valid[hit]      = 1'b1;
         tbl_id[hit]         = it.xfer_id;
         tbl_frag_total[hit] = it.frag_count[FRAG_CNT_W-1:0];
         tbl_byte_total[hit] = it.xfer_bytes;
         tbl_bytes_seen[hit] = '0;
         tbl_frags_seen[hit] = '0;
         tbl_seen[hit]       = '0;
      end
      r.slot = SLOT_OUT_W'(hit);

      if ({9'd0, tbl_frag_total[hit]} != it.frag_count ||
          tbl_byte_total[hit] != it.xfer_bytes) begin
         tbl_valid[hit] = 1'b0;
         r.status = ST_MISMATCH;
         return r;
      end
      tbl_last[hit] = it.now_ms;
      pos = it.frag_index[MAP_IW-1:0];
      if (tbl_seen[hit][pos]) begin
         r.status = ST_DUP;
         return r;
      end

      // Room left for earlier bytes once this fragment is counted; a fragment
      // longer than the whole transfer leaves none.
      take = ({16'd0, it.payload_len} < tbl_byte_total[hit]) ? {16'd0, it.payload_len}
                                                             : tbl_byte_total[hit];
      room = tbl_byte_total[hit] - take;
      if (tbl_bytes_seen[hit] > room) begin
         tbl_valid[hit] = 1'b0;
         r.status = ST_OVERFLOW;
         return r;
      end
      tbl_seen[hit][pos]  = 1'b1;
      tbl_bytes_seen[hit] = tbl_bytes_seen[hit] + {16'd0, it.payload_len};
      tbl_frags_seen[hit] = tbl_frags_seen[hit] + 1'b1;
      r.write_payload = 1'b1;
      if (tbl_frags_seen[hit] != tbl_frag_total[hit]) begin
         r.status = ST_STORED;
         return r;
      end
      // Last fragment in: the slot is released whether or not the sizes agree.
      tbl_valid[hit] = 1'b0;
      if (tbl_bytes_seen[hit] != tbl_byte_total[hit]) begin
         r.status = ST_SIZE_ERR;
         return r;
      end
      r.status = ST_COMPLETE;
      r.completed_size = tbl_byte_total[hit];
      return r;
   endfunction

   function automatic req_type make_frag(input logic [31:0] id, input logic [15:0] idx,
                                         input logic [15:0] cnt, input logic [31:0] total,
                                         input logic [15:0] len, input logic [63:0] now);
      req_type it;
      it = '0;
      it.cmd         = CMD_FRAG;
      it.xfer_id     = id;
      it.frag_index  = idx;
      it.frag_count  = cnt;
      it.xfer_bytes  = total;
      it.payload_len = len;
      it.now_ms      = now;
      return it;
   endfunction

   function automatic req_type plan_fragment(input int p, input int pos);
      return make_frag(plan_id[p], plan_order[p][pos], 16'(plan_cnt[p]), plan_total[p],
                       plan_len[p][pos], link_ms);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Issues one command. The sender may idle first; once start is up it stays
   // up until the edge that takes the transfer, and the outcome is predicted
   // at that edge so that commands are modeled in the order the block sees them.
   task automatic send_item(input req_type it);
      rsp_type owed;
      while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_cmd         <= it.cmd;
      req_transfer_id <= it.xfer_id;
      req_frag_index  <= it.frag_index;
      req_frag_count  <= it.frag_count;
      req_total_size  <= it.xfer_bytes;
      req_payload_len <= it.payload_len;
      req_now_ms      <= it.now_ms;
      @(posedge clock);
      while (busy) @(posedge clock);
      owed = table_outcome(it);
      results_due = {results_due, owed};
   endtask

   // Holds the sender off until every owed result has arrived. Every command
   // yields one result, so an empty list means nothing is in flight.
   task automatic wait_results_drained();
      start <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   // Leaves csr_valid high so that back-to-back register writes do not drop it.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_TIMEOUT:   cfg_timeout   = val;
         CSR_MAX_BYTES: cfg_max_bytes = val;
         CSR_FRAG_CAP:  cfg_frag_cap  = val[15:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [31:0] timeout, input logic [31:0] max_bytes,
                              input logic [15:0] frag_cap);
      wait_results_drained();
      write_register(CSR_TIMEOUT, timeout);
      write_register(CSR_MAX_BYTES, max_bytes);
      write_register(CSR_FRAG_CAP, {16'd0, frag_cap});
      csr_valid <= 1'b0;
   endtask

   // Builds a transfer that fits the current limits. Most are consistent and
   // complete cleanly; a few carry a total that disagrees with the sum of the
   // fragment lengths, which ends in a size error or an overflow.
   task automatic open_plan(input int p);
      int          cnt;
      int          k;
      int          j;
      logic [31:0] lim;
      logic [31:0] sum;
      logic [15:0] tmp;
      cnt = ($urandom_range(9) == 0) ? int'($urandom_range(MAX_FRAGMENTS, 1))
                                     : int'($urandom_range(8, 1));
      if (cfg_max_bytes < 32'(cnt)) cnt = int'(cfg_max_bytes);
      lim = cfg_max_bytes / 32'(cnt);
      if (lim > {16'd0, cfg_frag_cap}) lim = {16'd0, cfg_frag_cap};
      if (lim > 300 && $urandom_range(3) != 0) lim = 300;
      sum = '0;
      for (k = 0; k < cnt; k++) begin
         plan_len[p][k]   = 16'($urandom_range(lim, 1));
         plan_order[p][k] = 16'(k);
         sum = sum + {16'd0, plan_len[p][k]};
      end
      for (k = cnt - 1; k > 0; k--) begin
         j = int'($urandom_range(k));
         tmp = plan_order[p][k];
         plan_order[p][k] = plan_order[p][j];
         plan_order[p][j] = tmp;
      end
      case ($urandom_range(19))
         0: plan_total[p] = sum + $urandom_range(5, 1);
         1: plan_total[p] = (sum > 1) ? sum - 1 : sum;
         default: plan_total[p] = sum;
      endcase
      plan_id[p] = $urandom;
      if (plan_id[p] == '0) plan_id[p] = 32'd1;
      plan_cnt[p]  = cnt;
      plan_sent[p] = 0;
   endtask

   // Each header check in turn, against the reset limits, plus the unused
   // command code with every field at its all-ones extreme.
   task automatic test_header_checks();
      req_type it;
      send_item(make_frag(32'd0, 16'd0, 16'd1, 32'd100, 16'd100, 64'd1000));
      send_item(make_frag(32'd5, 16'd0, 16'd0, 32'd100, 16'd100, 64'd1000));
      send_item(make_frag(32'd5, 16'd4, 16'd4, 32'd100, 16'd10, 64'd1000));
      send_item(make_frag(32'd5, 16'd3, 16'd65, 32'd100, 16'd10, 64'd1000));
      send_item(make_frag(32'd5, 16'd0, 16'd2, 32'd0, 16'd10, 64'd1000));
      send_item(make_frag(32'd5, 16'd0, 16'd2, 32'd65537, 16'd10, 64'd1000));
      send_item(make_frag(32'd5, 16'd0, 16'd2, 32'd100, 16'd0, 64'd1000));
      send_item(make_frag(32'd5, 16'd0, 16'd2, 32'd100, 16'd1025, 64'd1000));
      it = make_frag('1, '1, '1, '1, '1, '1);
      it.cmd = CMD_RESERVED;
      send_item(it);
   endtask

   // A clean completion with a repeated index on the way, then a size error,
   // an overflow and a header that disagrees with its open slot.
   task automatic test_transfer_outcomes();
      send_item(make_frag(32'hFFFF_FFFF, 16'd1, 16'd2, 32'd2048, 16'd1024, 64'd2000));
      send_item(make_frag(32'hFFFF_FFFF, 16'd1, 16'd2, 32'd2048, 16'd1024, 64'd2001));
      send_item(make_frag(32'hFFFF_FFFF, 16'd0, 16'd2, 32'd2048, 16'd1024, 64'd2002));
      send_item(make_frag(32'd7, 16'd0, 16'd1, 32'd10, 16'd5, 64'd2003));
      send_item(make_frag(32'd8, 16'd0, 16'd2, 32'd10, 16'd8, 64'd2004));
      send_item(make_frag(32'd8, 16'd1, 16'd2, 32'd10, 16'd8, 64'd2005));
      send_item(make_frag(32'd9, 16'd0, 16'd3, 32'd30, 16'd10, 64'd2006));
      send_item(make_frag(32'd9, 16'd0, 16'd4, 32'd30, 16'd10, 64'd2007));
   endtask

   // Fills all eight slots with the highest legal index and count, then one
   // more id finds no room. The last slot is stamped far ahead of the others.
   // The time base sits near the top of the 64-bit range.
   task automatic test_table_full();
      logic [63:0] t;
      int          s;
      t = 64'hFFFF_FFFF_FFF0_0000;
      for (s = 0; s < SLOTS; s++)
         send_item(make_frag(32'd100 + 32'(s), 16'd63, 16'd64, 32'd65536, 16'd1,
                             (s == SLOTS - 1) ? t + 64'd1_000_000 : t));
      send_item(make_frag(32'd200, 16'd0, 16'd64, 32'd65536, 16'd1, t));
   endtask

   // An age equal to the timeout keeps a slot; one more millisecond frees it.
   // The slot stamped in the future survives both sweeps.
   task automatic test_expiry();
      req_type     it;
      logic [63:0] t;
      t = 64'hFFFF_FFFF_FFF0_0000;
      it = '0;
      it.cmd = CMD_SWEEP;
      it.now_ms = t + 64'd5000;
      send_item(it);
      it.now_ms = t + 64'd5001;
      send_item(it);
   endtask

   task automatic test_clear();
      req_type it;
      it = '0;
      it.cmd = CMD_CLEAR;
      send_item(it);
   endtask

   // Mostly well-formed transfers interleaved across up to PLANS ids, more than
   // the table holds, mixed with repeated fragments, conflicting headers, sweeps
   // at and around the timeout, the odd clear and random noise on every field.
   task automatic test_random_traffic(input int items, input int gap_pct);
      int          done;
      int          p;
      int          act;
      int          j;
      req_type     it;
      logic [63:0] stamp;
      sender_gap_pct = gap_pct;
      active_plans = int'($urandom_range(PLANS, 1));
      for (p = 0; p < PLANS; p++) begin
         plan_cnt[p]  = 0;
         plan_sent[p] = 0;
      end
      link_ms = {$urandom, $urandom} >> $urandom_range(63, 1);
      for (done = 0; done < items; done++) begin
         // Halfway through, the sender stops until the table has answered all.
         if (done == items / 2) wait_results_drained();
         if ($urandom_range(49) == 0) active_plans = int'($urandom_range(PLANS, 1));
         p = int'($urandom_range(active_plans - 1));
         if (plan_sent[p] >= plan_cnt[p]) open_plan(p);
         link_ms = link_ms + 64'($urandom_range(40));
         act = int'($urandom_range(99));
         it = '0;
         if (act < 80) begin
            it = plan_fragment(p, plan_sent[p]);
            plan_sent[p]++;
         end else if (act < 85) begin
            j = (plan_sent[p] == 0) ? 0 : int'($urandom_range(plan_sent[p] - 1));
            it = plan_fragment(p, j);
         end else if (act < 88) begin
            it = plan_fragment(p, plan_sent[p]);
            if ($urandom_range(1) == 0) it.frag_count = it.frag_count + 16'd1;
            else it.xfer_bytes = it.xfer_bytes + $urandom_range(100, 1);
         end else if (act < 93) begin
            case ($urandom_range(3))
               0: stamp = link_ms + 64'($urandom_range(100));
               1: stamp = link_ms + {32'd0, cfg_timeout} + 64'($urandom_range(2));
               2: stamp = link_ms - 64'($urandom_range(1000, 1));
               default: stamp = link_ms + {32'd0, cfg_timeout} + 64'($urandom);
            endcase
            it.cmd = CMD_SWEEP;
            it.now_ms = stamp;
            if (stamp > link_ms && $urandom_range(1) == 0) link_ms = stamp;
         end else if (act < 94) begin
            it.cmd = CMD_CLEAR;
         end else begin
            it.cmd         = 2'($urandom_range(3));
            it.xfer_id     = ($urandom_range(3) == 0) ? plan_id[p] : $urandom;
            it.frag_index  = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(70));
            it.frag_count  = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(70));
            it.xfer_bytes  = $urandom >> $urandom_range(31);
            it.payload_len = 16'($urandom >> $urandom_range(31));
            it.now_ms      = {$urandom, $urandom};
         end
         send_item(it);
      end
   endtask

   // Every result is taken at the edge that ends its one-cycle strobe and is
   // held up against the oldest owed outcome, field by field.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (results_due.size() == 0) begin
            report_mismatch("unexpected result, status", 64'(rsp_status), '0);
         end else begin
            want = results_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_slot !== want.slot)
               report_mismatch("slot", 64'(rsp_slot), 64'(want.slot));
            if (rsp_write_payload !== want.write_payload)
               report_mismatch("write_payload", 64'(rsp_write_payload),
                               64'(want.write_payload));
            if (rsp_completed_size !== want.completed_size)
               report_mismatch("completed_size", 64'(rsp_completed_size),
                               64'(want.completed_size));
            if (rsp_expired_mask !== want.expired_mask)
               report_mismatch("expired_mask", 64'(rsp_expired_mask),
                               64'(want.expired_mask));
         end
      end
   end

   // Ends a run that has stopped making progress on every channel.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_cmd         <= CMD_FRAG;
      req_transfer_id <= '0;
      req_frag_index  <= '0;
      req_frag_count  <= '0;
      req_total_size  <= '0;
      req_payload_len <= '0;
      req_now_ms      <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_TIMEOUT;
      csr_wdata       <= '0;
      mismatch_count  = 0;
      sender_gap_pct  = 0;
      cfg_timeout     = TIMEOUT_RST;
      cfg_max_bytes   = MAX_BYTES_RST;
      cfg_frag_cap    = FRAG_CAP_RST;
      for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The short directed part runs on the reset register values.
      test_header_checks();
      test_transfer_outcomes();
      test_table_full();
      test_expiry();
      test_clear();

      // Random phases, each under its own limits and sender pacing. The timeout
      // is set to both extremes, the other two registers to their largest value and to one.
      load_config(TIMEOUT_RST, MAX_BYTES_RST, FRAG_CAP_RST);
      test_random_traffic(300, 0);
      load_config(32'd0, 32'hFFFF_FFFF, 16'hFFFF);
      test_random_traffic(300, 58);
      load_config(32'hFFFF_FFFF, 32'd1, 16'd1);
      test_random_traffic(150, 0);
      load_config($urandom_range(20000, 1), $urandom_range(200000, 256),
                  16'($urandom_range(1024, 1)));
      test_random_traffic(300, 26);
      load_config(32'd1000, 32'd4096, 16'd600);
      test_random_traffic(220, 0);

      // Everything has been sent. Wait for the owed results, then keep watching
      // so that a stray extra result would still be caught.
      wait_results_drained();
      repeat (4) @(posedge clock);
      if (results_due.size() != 0)
         report_mismatch("outstanding results at end, count", 64'(results_due.size()), '0);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/frt_pkg.sv
rtl/frt_header_check.sv
rtl/frt_slot_table.sv
rtl/fragment_reassembly_tracker_unit.sv
rtl/frt_checker.sv
dv/tb_top.sv
